>>> rtl/tpap_pkg.sv
// tpap_pkg: types and character constants for the touch packet parser
// no dependencies; imported by the interfaces and all rtl modules

package tpap_pkg;

   typedef logic [7:0]         byte_type;
   typedef logic [13:0]        run_type;
   typedef logic signed [14:0] ypos_type;

   typedef struct packed {
      logic step;
      logic first;
   } acc_ctrl_type;

   localparam byte_type CR_BYTE    = 8'd13;
   localparam byte_type CHAR_COMMA = 8'h2c;
   localparam byte_type CHAR_T     = 8'h54;
   localparam byte_type CHAR_R     = 8'h52;
   localparam byte_type CHAR_0     = 8'h30;
   localparam byte_type CHAR_9     = 8'h39;

   localparam run_type  RUN_MAX    = 14'd9999;
   localparam ypos_type Y_BASE     = 15'sd1024;

   localparam logic [3:0] TAG_POS   = 4'd0;
   localparam logic [3:0] X_START   = 4'd1;
   localparam logic [3:0] COMMA_POS = 4'd5;
   localparam logic [3:0] Y_START   = 4'd6;

endpackage

>>> rtl/tpap_req_if.sv
// tpap_req_if: valid/ready channel carrying one received serial byte per beat
// depends on tpap_pkg

interface tpap_req_if
   import tpap_pkg::*;
();
   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/tpap_rsp_if.sv
// tpap_rsp_if: valid/ready channel carrying one decoded touch result per beat
// depends on tpap_pkg

interface tpap_rsp_if
   import tpap_pkg::*;
();
   logic     valid;
   logic     ready;
   run_type  x_pos;
   ypos_type y_pos;
   logic     touching;

   modport source (output valid, output x_pos, output y_pos, output touching, input ready);
   modport sink   (input valid, input x_pos, input y_pos, input touching, output ready);
endinterface

>>> rtl/touch_packet_ascii_parser.sv
// touch_packet_ascii_parser: top level of the serial touch packet decoder
// depends on tpap_pkg, tpap_req_if, tpap_rsp_if and tpap_digit_acc
//
// usage:
//  req_chan takes one received byte per beat; a carriage return ends a packet.
//  bytes are captured in an input register, then decoded on the fly: the tag
//  byte, the comma position and both digit runs are folded into running
//  registers as bytes arrive, so the packet needs no byte buffer.
//  rsp_chan gives one beat (x_pos, y_pos, touching) for each valid packet of
//  at least PACKET_LEN bytes, extra bytes being ignored; invalid, short or empty packets give nothing.
//  throughput: one byte per cycle, set by the single multiply-add step of the
//  digit accumulators, except while a carriage return is held (see stall).
//  result path: a carriage return is captured in the input register, and the
//  result beat is registered from it once any pending result has been taken.
//  reset: synchronous, clears the input register valid, the byte count and the
//  result valid; the first packet after reset starts at byte 0.
//  stall: while a result waits on rsp_chan, data bytes keep flowing; a second
//  carriage return waits in the input register and holds req_chan.ready low
//  until the pending result is taken.

module touch_packet_ascii_parser
   import tpap_pkg::*;
#(
   parameter int PACKET_LEN = 10
) (
   input logic        clock,
   input logic        reset,
   tpap_req_if.sink   req_chan,
   tpap_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(PACKET_LEN + 1);
   localparam logic [CNT_W-1:0] LEN_C = CNT_W'(PACKET_LEN);

   logic             s1_valid_ff, s1_valid_in;
   byte_type         s1_byte_ff, s1_byte_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             is_t_ff, is_t_in;
   logic             is_r_ff, is_r_in;
   logic             comma_ff, comma_in;
   logic             rsp_valid_ff, rsp_valid_in;
   run_type          x_ff, x_in;
   ypos_type         y_ff, y_in;
   logic             touch_ff, touch_in;

   logic         accept, s1_cr, out_free, s1_fire, store, emit;
   acc_ctrl_type x_ctrl, y_ctrl;
   run_type      x_run, y_run;

   assign accept   = req_chan.valid && req_chan.ready;
   assign s1_cr    = (s1_byte_ff == CR_BYTE);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_fire  = s1_valid_ff && (out_free || !s1_cr);
   assign store    = s1_fire && !s1_cr && (count_ff < LEN_C);
   assign emit     = s1_fire && s1_cr && (count_ff == LEN_C) && comma_ff
                     && (is_t_ff || is_r_ff);

   assign req_chan.ready = !s1_valid_ff || s1_fire;

   // digit runs start at the first x digit and after the comma
   assign x_ctrl.step  = store && (count_ff >= CNT_W'(X_START));
   assign x_ctrl.first = (count_ff == CNT_W'(X_START));
   assign y_ctrl.step  = store && (count_ff >= CNT_W'(Y_START));
   assign y_ctrl.first = (count_ff == CNT_W'(Y_START));

   tpap_digit_acc u_x_acc (
      .clock     (clock),
      .ctrl      (x_ctrl),
      .data      (s1_byte_ff),
      .run_value (x_run)
   );

   tpap_digit_acc u_y_acc (
      .clock     (clock),
      .ctrl      (y_ctrl),
      .data      (s1_byte_ff),
      .run_value (y_run)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_chan.rx_byte;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      count_in = count_ff;
      is_t_in  = is_t_ff;
      is_r_in  = is_r_ff;
      comma_in = comma_ff;
      if (s1_fire && s1_cr) begin
         count_in = '0;
      end else if (store) begin
         count_in = count_ff + CNT_W'(1);
         if (count_ff == CNT_W'(TAG_POS)) begin
            is_t_in = (s1_byte_ff == CHAR_T);
            is_r_in = (s1_byte_ff == CHAR_R);
         end
         if (count_ff == CNT_W'(COMMA_POS)) begin
            comma_in = (s1_byte_ff == CHAR_COMMA);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      touch_in     = touch_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         x_in         = x_run;
         y_in         = Y_BASE - $signed({1'b0, y_run});
         touch_in     = is_t_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      is_t_ff    <= is_t_in;
      is_r_ff    <= is_r_in;
      comma_ff   <= comma_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      touch_ff   <= touch_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.x_pos    = x_ff;
   assign rsp_chan.y_pos    = y_ff;
   assign rsp_chan.touching = touch_ff;

endmodule

>>> rtl/tpap_digit_acc.sv
// tpap_digit_acc: running decimal value of one digit run, one byte per step,
// saturating at 9999; depends on tpap_pkg

module tpap_digit_acc
   import tpap_pkg::*;
(
   input  logic         clock,
   input  acc_ctrl_type ctrl,
   input  byte_type     data,
   output run_type      run_value
);

   logic        is_digit;
   logic [3:0]  digit;
   logic [16:0] next_sum;
   run_type     sat_sum;
   run_type     acc_ff, acc_in;
   logic        active_ff, active_in;

   assign is_digit = (data >= CHAR_0) && (data <= CHAR_9);
   assign digit    = 4'(data - CHAR_0);
   assign next_sum = {3'b000, acc_ff} * 17'd10 + {13'd0, digit};
   assign sat_sum  = (next_sum > {3'b000, RUN_MAX}) ? RUN_MAX : next_sum[13:0];

   always_comb begin
      acc_in    = acc_ff;
      active_in = active_ff;
      if (ctrl.step) begin
         if (ctrl.first) begin
            active_in = is_digit;
            acc_in    = is_digit ? {10'd0, digit} : '0;
         end else if (active_ff && is_digit) begin
            acc_in = sat_sum;
         end else begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      active_ff <= active_in;
   end

   assign run_value = acc_ff;

endmodule

>>> dv/touch_packet_ascii_parser_tb.sv
// touch_packet_ascii_parser_tb: self-checking bench for the serial touch packet decoder
// streams directed and random packets, predicts each decoded touch and checks rsp beats
// depends on tpap_pkg, tpap_req_if, tpap_rsp_if and touch_packet_ascii_parser

module touch_packet_ascii_parser_tb;
   import tpap_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PACKET_LEN   = 10;
   localparam int RANDOM_BYTES = 1300;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      run_type  x_pos;
      ypos_type y_pos;
      logic     touching;
   } touch_report_type;

   typedef byte_type byte_q_type[$];

   typedef struct {
      string            text;
      bit               typed;
      bit               has_touch;
      touch_report_type touch;
   } probe_row_type;

   logic clock = 1'b0;
   logic reset;

   tpap_req_if req_chan ();
   tpap_rsp_if rsp_chan ();

   touch_packet_ascii_parser #(.PACKET_LEN(PACKET_LEN)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #2 clock = ~clock;

   // carriage return is appended to every row
   probe_row_type probe_rows [7] = '{
      '{"",                1'b1, 1'b0, '{14'd0,    15'sd0,     1'b0}},
      '{"T0000,0000",      1'b1, 1'b1, '{14'd0,    15'sd1024,  1'b1}},
      '{"R9999,9999",      1'b1, 1'b1, '{14'd9999, -15'sd8975, 1'b0}},
      '{"T123,4567",       1'b1, 1'b0, '{14'd0,    15'sd0,     1'b0}},
      '{"T1234;5678",      1'b1, 1'b0, '{14'd0,    15'sd0,     1'b0}},
      '{"X1234,5678",      1'b1, 1'b0, '{14'd0,    15'sd0,     1'b0}},
      '{"R12/4,\3776:8ZZ", 1'b0, 1'b0, '{14'd0,    15'sd0,     1'b0}}
   };

   touch_report_type expected_touches[$];
   byte_type         pkt_buf [PACKET_LEN];
   int unsigned      pkt_count = 0;

   int unsigned errors         = 0;
   int unsigned cycles         = 0;
   int unsigned beats_in       = 0;
   int unsigned results_seen   = 0;
   int unsigned packets_sent   = 0;
   bit          steady_stretch = 1'b0;
   bit          long_hold_req  = 1'b0;

   function automatic void log_error(input string msg);
      errors++;
      if (errors <= 10) $display("ERROR cycle %0d: %s", cycles, msg);
   endfunction

   function automatic int unsigned run_value(input int first);
      int unsigned acc = 0;
      for (int i = first; i < PACKET_LEN; i++) begin
         if (pkt_buf[i] < CHAR_0 || pkt_buf[i] > CHAR_9) break;
         acc = acc * 10 + int'(pkt_buf[i] - CHAR_0);
         if (acc > RUN_MAX) acc = RUN_MAX;
      end
      return acc;
   endfunction

   function automatic bit decode_rx_byte(input byte_type b, output touch_report_type r);
      int unsigned yv;
      bit          made = 1'b0;
      r = '0;
      if (b == CR_BYTE) begin
         if (pkt_count == PACKET_LEN && pkt_buf[COMMA_POS] == CHAR_COMMA &&
             (pkt_buf[TAG_POS] == CHAR_T || pkt_buf[TAG_POS] == CHAR_R)) begin
            yv         = run_value(Y_START);
            r.x_pos    = run_type'(run_value(X_START));
            r.y_pos    = ypos_type'(int'(Y_BASE) - int'(yv));
            r.touching = (pkt_buf[TAG_POS] == CHAR_T);
            made       = 1'b1;
         end
         pkt_count = 0;
      end else if (pkt_count < PACKET_LEN) begin
         pkt_buf[pkt_count] = b;
         pkt_count++;
      end
      return made;
   endfunction

   function automatic byte_q_type random_packet();
      byte_q_type p;
      int         mode;
      int         cut;
      mode = $urandom_range(99);
      if (mode < 10) begin
         repeat ($urandom_range(14)) p.push_back(byte_type'($urandom_range(255)));
      end else begin
         p.push_back($urandom_range(1) ? CHAR_T : CHAR_R);
         for (int i = 1; i < PACKET_LEN; i++) begin
            if (i == COMMA_POS) p.push_back(CHAR_COMMA);
            else if ($urandom_range(9) != 0) p.push_back(byte_type'(CHAR_0 + $urandom_range(9)));
            else p.push_back(byte_type'($urandom_range(255)));
         end
         if (mode >= 72 && mode < 80) begin
            cut = $urandom_range(PACKET_LEN - 1);
            while (p.size() > cut) void'(p.pop_back());
         end else if (mode >= 80 && mode < 88) begin
            repeat ($urandom_range(6, 1)) p.push_back(byte_type'($urandom_range(255)));
         end else if (mode >= 88) begin
            p[$urandom_range(PACKET_LEN - 1)] = byte_type'($urandom_range(255));
         end
      end
      p.push_back(CR_BYTE);
      return p;
   endfunction

   // called and returns on a falling edge; valid is left high after the beat
   task automatic push_byte(input byte_type b, output bit made, output touch_report_type r);
      while (!steady_stretch && $urandom_range(99) < 37) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      made = decode_rx_byte(b, r);
      beats_in++;
      @(negedge clock);
   endtask

   // returns on a later falling edge than the one it was called on
   task automatic pause_until_drained();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (expected_touches.size() != 0);
   endtask

   initial begin
      int unsigned      rand_bytes;
      int unsigned      drain_wait;
      int               len;
      bit               made;
      byte_type         b;
      touch_report_type got;
      byte_q_type       pkt;

      rand_bytes       = 0;
      drain_wait       = 0;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      foreach (probe_rows[r]) begin
         len = probe_rows[r].text.len();
         for (int i = 0; i <= len; i++) begin
            b = (i < len) ? byte_type'(probe_rows[r].text[i]) : CR_BYTE;
            push_byte(b, made, got);
            if (i == len && probe_rows[r].typed) begin
               made = probe_rows[r].has_touch;
               got  = probe_rows[r].touch;
            end
            if (made) expected_touches.push_back(got);
         end
         packets_sent++;
      end
      pause_until_drained();

      while (rand_bytes < RANDOM_BYTES) begin
         if (packets_sent == 30) long_hold_req = 1'b1;
         if (packets_sent == 55) pause_until_drained();
         steady_stretch = (packets_sent >= 70 && packets_sent < 95);
         pkt = random_packet();
         foreach (pkt[i]) begin
            push_byte(pkt[i], made, got);
            if (made) expected_touches.push_back(got);
            rand_bytes++;
         end
         packets_sent++;
      end
      req_chan.valid <= 1'b0;

      while (expected_touches.size() != 0 && drain_wait < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (8) @(posedge clock);
      if (expected_touches.size() != 0)
         log_error($sformatf("%0d expected results never arrived", expected_touches.size()));

      $display("run covered %0d beats in %0d packets, %0d decoded touches checked",
               beats_in, packets_sent, results_seen);
      $display("with a long output hold, a drained pause and a gap-free stretch");
      if (errors == 0) begin
         $display("touch_packet_ascii_parser: match");
      end else begin
         $display("touch_packet_ascii_parser: mismatch");
      end
      $finish;
   end

   initial begin
      int unsigned hold_left;
      hold_left      = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= steady_stretch || ($urandom_range(99) >= 37);
         end
      end
   end

   always @(posedge clock) begin
      touch_report_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (expected_touches.size() == 0) begin
            log_error($sformatf("unexpected beat x_pos %0d y_pos %0d touching %0b",
                                rsp_chan.x_pos, rsp_chan.y_pos, rsp_chan.touching));
         end else begin
            want = expected_touches.pop_front();
            if (rsp_chan.x_pos !== want.x_pos)
               log_error($sformatf("x_pos got %0d expected %0d", rsp_chan.x_pos, want.x_pos));
            if (rsp_chan.y_pos !== want.y_pos)
               log_error($sformatf("y_pos got %0d expected %0d", rsp_chan.y_pos, want.y_pos));
            if (rsp_chan.touching !== want.touching)
               log_error($sformatf("touching got %0b expected %0b",
                                   rsp_chan.touching, want.touching));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, expected_touches.size());
         $display("touch_packet_ascii_parser: mismatch");
         $finish;
      end
   end

endmodule

>>> touch_packet_ascii_parser.f
rtl/tpap_pkg.sv
rtl/tpap_req_if.sv
rtl/tpap_rsp_if.sv
rtl/tpap_digit_acc.sv
rtl/touch_packet_ascii_parser.sv
dv/touch_packet_ascii_parser_tb.sv
